### design/msis_pkg.sv
`default_nettype none

package msis_pkg;

  localparam int unsigned BOOT_TICKS = 3;
  localparam logic [15:0] SPEED_LIMIT = 16'd250;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXPIRY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_MASK = 2'd2;

  typedef enum logic [1:0] {
    MODE_BOOT    = 2'd0,
    MODE_SAFE    = 2'd1,
    MODE_PERMIT  = 2'd2,
    MODE_LATCHED = 2'd3
  } mode_t;

  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_CONFIG   = 3'd1;
  localparam logic [2:0] FAULT_TORQUE   = 3'd2;
  localparam logic [2:0] FAULT_BUS_TX   = 3'd3;
  localparam logic [2:0] FAULT_DROPOUT  = 3'd4;
  localparam logic [2:0] FAULT_ROLLBACK = 3'd5;
  localparam logic [2:0] FAULT_INVALID  = 3'd6;

  localparam logic [3:0] REJ_NONE        = 4'd0;
  localparam logic [3:0] REJ_NO_REQUEST  = 4'd1;
  localparam logic [3:0] REJ_UNAUTH      = 4'd2;
  localparam logic [3:0] REJ_UNSUPERVISED = 4'd3;
  localparam logic [3:0] REJ_EXPIRY_RANGE = 4'd4;
  localparam logic [3:0] REJ_EXPIRED     = 4'd5;
  localparam logic [3:0] REJ_REPLAY      = 4'd6;
  localparam logic [3:0] REJ_SPEED       = 4'd7;
  localparam logic [3:0] REJ_LOCKED      = 4'd8;
  localparam logic [3:0] REJ_FAULTED     = 4'd9;

  // status_flags bit positions
  localparam int unsigned ST_VALID    = 0;
  localparam int unsigned ST_RESET    = 1;
  localparam int unsigned ST_PERMIT   = 2;
  localparam int unsigned ST_DISABLED = 3;
  localparam int unsigned ST_DIGEST   = 4;

  // request_flags bit positions
  localparam int unsigned RQ_PRESENT = 0;
  localparam int unsigned RQ_AUTH    = 1;
  localparam int unsigned RQ_SUPER   = 2;
  localparam int unsigned RQ_STOP    = 3;

  typedef struct packed {
    logic [31:0] now_time_ms;
    logic [4:0]  status_flags;
    logic [31:0] observed_torque_mask;
    logic [15:0] observed_bus_mask;
    logic [3:0]  request_flags;
    logic [15:0] request_expiry_ms;
    logic [31:0] request_issued_ms;
    logic [31:0] request_sequence;
    logic [15:0] request_speed_permille;
  } msis_in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  fault_code;
    logic        fault_flag;
    logic        heartbeat;
    logic [3:0]  reject_code;
    logic [31:0] accepted_sequence;
  } msis_out_t;

  typedef struct packed {
    logic [15:0] max_expiry_ms;
    logic [31:0] axis_mask;
    logic [15:0] bus_mask;
  } msis_cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  fault;
    logic        fault_flag;
    logic        heartbeat;
    logic [3:0]  reject;
    logic [31:0] accepted_seq;
    logic [31:0] highest_seq;
    logic [31:0] last_time;
    logic        time_seen;
    logic        permit_seen;
    logic [1:0]  boot_count;
  } msis_state_t;

  localparam msis_cfg_t CFG_RESET = '{
    max_expiry_ms: 16'd1000,
    axis_mask:     32'hFFFF_FFFF,
    bus_mask:      16'hFFFF
  };

  localparam msis_state_t STATE_RESET = '{
    mode:         MODE_BOOT,
    fault:        FAULT_NONE,
    fault_flag:   1'b0,
    heartbeat:    1'b0,
    reject:       REJ_NO_REQUEST,
    accepted_seq: 32'd0,
    highest_seq:  32'd0,
    last_time:    32'd0,
    time_seen:    1'b0,
    permit_seen:  1'b0,
    boot_count:   2'd0
  };

endpackage

`default_nettype wire

### design/msis_core.sv
`default_nettype none

module msis_core
  import msis_pkg::*;
(
  input  wire msis_state_t state,
  input  wire msis_cfg_t   cfg,
  input  wire msis_in_t    item,
  output msis_state_t      state_nxt
);

  function automatic msis_state_t raise_fault(msis_state_t s, logic [2:0] code);
    msis_state_t f;
    f = s;
    f.heartbeat  = 1'b0;
    f.mode       = MODE_LATCHED;
    f.fault      = code;
    f.fault_flag = 1'b1;
    f.reject     = REJ_FAULTED;
    return f;
  endfunction

  logic        valid, reset_req, permit, disabled, digest;
  logic        clear_ok;
  logic [31:0] elapsed;
  logic [3:0]  rej;

  assign valid     = item.status_flags[ST_VALID];
  assign reset_req = item.status_flags[ST_RESET];
  assign permit    = item.status_flags[ST_PERMIT];
  assign disabled  = item.status_flags[ST_DISABLED];
  assign digest    = item.status_flags[ST_DIGEST];

  // unmasked observed masks must both be quiet to leave the latched state
  assign clear_ok = reset_req && !permit && disabled && digest &&
                    (item.observed_torque_mask == '0) && (item.observed_bus_mask == '0);

  assign elapsed = item.now_time_ms - item.request_issued_ms;

  // first failing check wins
  always_comb begin
    if (!item.request_flags[RQ_PRESENT]) begin
      rej = REJ_NO_REQUEST;
    end else if (!item.request_flags[RQ_AUTH]) begin
      rej = REJ_UNAUTH;
    end else if (!item.request_flags[RQ_SUPER]) begin
      rej = REJ_UNSUPERVISED;
    end else if ((item.request_expiry_ms == '0) ||
                 (item.request_expiry_ms > cfg.max_expiry_ms)) begin
      rej = REJ_EXPIRY_RANGE;
    end else if (elapsed > {16'd0, item.request_expiry_ms}) begin
      rej = REJ_EXPIRED;
    end else if (item.request_sequence <= state.highest_seq) begin
      rej = REJ_REPLAY;
    end else if (item.request_speed_permille > SPEED_LIMIT) begin
      rej = REJ_SPEED;
    end else if (!item.request_flags[RQ_STOP]) begin
      rej = REJ_LOCKED;
    end else begin
      rej = REJ_NONE;
    end
  end

  always_comb begin
    state_nxt = state;
    if (!valid) begin
      state_nxt = raise_fault(state, FAULT_INVALID);
    end else if (state.mode == MODE_LATCHED) begin
      state_nxt.heartbeat = 1'b0;
      if (clear_ok) begin
        state_nxt.mode        = MODE_SAFE;
        state_nxt.fault       = FAULT_NONE;
        state_nxt.fault_flag  = 1'b0;
        state_nxt.reject      = REJ_NO_REQUEST;
        state_nxt.permit_seen = 1'b0;
        state_nxt.boot_count  = 2'd0;
      end
    end else if (state.time_seen && (item.now_time_ms < state.last_time)) begin
      state_nxt = raise_fault(state, FAULT_ROLLBACK);
    end else begin
      state_nxt.heartbeat = ~state.heartbeat;
      state_nxt.time_seen = 1'b1;
      state_nxt.last_time = item.now_time_ms;
      if (!digest) begin
        state_nxt = raise_fault(state_nxt, FAULT_CONFIG);
      end else if (!disabled || ((item.observed_torque_mask & cfg.axis_mask) != '0)) begin
        state_nxt = raise_fault(state_nxt, FAULT_TORQUE);
      end else if ((item.observed_bus_mask & cfg.bus_mask) != '0) begin
        state_nxt = raise_fault(state_nxt, FAULT_BUS_TX);
      end else if (state.permit_seen && !permit) begin
        state_nxt = raise_fault(state_nxt, FAULT_DROPOUT);
      end else if (32'(state.boot_count) < BOOT_TICKS) begin
        state_nxt.boot_count = state.boot_count + 2'd1;
        state_nxt.mode       = MODE_BOOT;
        state_nxt.reject     = REJ_NO_REQUEST;
      end else if (!permit) begin
        state_nxt.mode   = MODE_SAFE;
        state_nxt.reject = REJ_NO_REQUEST;
      end else begin
        state_nxt.permit_seen = 1'b1;
        state_nxt.mode        = MODE_PERMIT;
        state_nxt.reject      = rej;
        if (rej == REJ_NONE) begin
          state_nxt.highest_seq  = item.request_sequence;
          state_nxt.accepted_seq = item.request_sequence;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/motion_safety_interlock_supervisor.sv
// Motion safety interlock supervisor.
//
// in_valid/in_stall/in_data carry one control tick per word; a word is taken
// on a clock edge with in_valid high and in_stall low. Every tick yields one
// result word on out_valid/out_stall/out_data, holding the safety mode, the
// fault code and flag, the heartbeat, the request reject code and the last
// accepted stop sequence, all as they stand after that tick.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the expiry limit (index 0),
// the axis mask (1) and the bus mask (2); cfg_ready is always high and
// unknown indexes are dropped. Write configuration only while idle.
// A tick passes the input register, then the result register, on its way
// to out_data. One tick per cycle is sustained while the receiver does not
// stall: the whole check chain sits between the input register and the
// result register, and the state updates in that cycle. When the receiver
// stalls, the result and input registers hold and in_stall rises in the
// same cycle; nothing is lost or repeated. Reset (rst_n low, synchronous)
// clears both stages, returns to boot hold with no fault and reloads the configuration defaults.
`default_nettype none

module motion_safety_interlock_supervisor
  import msis_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,

  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire msis_in_t        in_data,

  output logic                 out_valid,
  input  wire                  out_stall,
  output msis_out_t            out_data,

  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  logic        in_valid_r;
  msis_in_t    in_data_r;
  logic        out_valid_r;
  msis_out_t   out_data_r;
  msis_state_t state_r;
  msis_state_t state_nxt;
  msis_cfg_t   cfg_r;
  logic        advance;

  // move both stages whenever the result slot is free or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  msis_core u_core (
    .state     (state_r),
    .cfg       (cfg_r),
    .item      (in_data_r),
    .state_nxt (state_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
      cfg_r       <= CFG_RESET;
    end else begin
      if (advance) begin
        in_valid_r  <= in_valid;
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_EXPIRY: cfg_r.max_expiry_ms <= cfg_data[15:0];
          CFG_AXIS_MASK:  cfg_r.axis_mask     <= cfg_data;
          CFG_BUS_MASK:   cfg_r.bus_mask      <= cfg_data[15:0];
          default:        ;
        endcase
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      in_data_r <= in_data;
      if (in_valid_r) begin
        out_data_r.mode              <= state_nxt.mode;
        out_data_r.fault_code        <= state_nxt.fault;
        out_data_r.fault_flag        <= state_nxt.fault_flag;
        out_data_r.heartbeat         <= state_nxt.heartbeat;
        out_data_r.reject_code       <= state_nxt.reject;
        out_data_r.accepted_sequence <= state_nxt.accepted_seq;
      end
    end
  end

endmodule

`default_nettype wire

### design/msis_checker.sv
`default_nettype none

module msis_checker
  import msis_pkg::*;
(
  input wire            clk,
  input wire            rst_n,
  input wire            out_valid,
  input wire            out_stall,
  input wire msis_out_t out_data
);

  // no result leaves reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // latched mode carries the full fault signature
  a_latched_sig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.mode == MODE_LATCHED) |->
      out_data.fault_flag && !out_data.heartbeat && (out_data.reject_code == REJ_FAULTED))
    else $error("latched mode without fault signature");

  // a fault code or flag is shown only in latched mode
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.fault_code != FAULT_NONE) || out_data.fault_flag) |->
      (out_data.mode == MODE_LATCHED) && (out_data.fault_code != FAULT_NONE))
    else $error("fault shown outside latched mode");

endmodule

bind motion_safety_interlock_supervisor msis_checker u_msis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import msis_pkg::*;

  // Status and request flag combinations, built from the package bit positions.
  localparam logic [4:0] ST_HEALTHY = 5'(1 << ST_VALID) | 5'(1 << ST_DISABLED) |
                                      5'(1 << ST_DIGEST);
  localparam logic [4:0] ST_CLEAR_REQ = ST_HEALTHY | 5'(1 << ST_RESET);
  localparam logic [4:0] ST_PERMIT_BIT = 5'(1 << ST_PERMIT);
  localparam logic [3:0] RQ_ALL = 4'(1 << RQ_PRESENT) | 4'(1 << RQ_AUTH) |
                                  4'(1 << RQ_SUPER) | 4'(1 << RQ_STOP);
  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  msis_in_t in_data = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  msis_out_t out_data;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  motion_safety_interlock_supervisor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 50 MHz clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Our own copy of the limit registers, kept in step with every write.
  logic [15:0] lim_expiry = CFG_RESET.max_expiry_ms;
  logic [31:0] lim_axes = CFG_RESET.axis_mask;
  logic [15:0] lim_buses = CFG_RESET.bus_mask;

  // Interlock state as the supervisor should hold it after the last accepted tick.
  mode_t ilk_mode = MODE_BOOT;
  logic [2:0] ilk_fault = FAULT_NONE;
  logic ilk_flag = 1'b0;
  logic ilk_beat = 1'b0;
  logic [3:0] ilk_reject = REJ_NO_REQUEST;
  logic [31:0] ilk_accepted = '0;
  logic [31:0] ilk_highest = '0;
  logic [31:0] ilk_last_time = '0;
  logic ilk_time_seen = 1'b0;
  logic ilk_permit_seen = 1'b0;
  logic [1:0] ilk_boot = '0;

  // Status words still owed by the block, oldest first.
  msis_out_t pending_status[$];

  int ticks_sent = 0;
  int words_checked = 0;
  int field_errors = 0;
  int stray_words = 0;
  int reports = 0;
  int trips = 0;
  int grants = 0;

  // Traffic shaping knobs, in percent per cycle.
  int send_idle_pct = 0;
  int stall_pct = 0;
  // Cycles of forced receiver hold-off still to run.
  int hold_req = 0;

  // Latch a fault: drop heartbeat, flag it and refuse every request.
  function automatic void trip(input logic [2:0] code);
    ilk_beat = 1'b0;
    ilk_mode = MODE_LATCHED;
    ilk_fault = code;
    ilk_flag = 1'b1;
    ilk_reject = REJ_FAULTED;
    trips++;
  endfunction

  // Advance the interlock by one control tick and return the status word it
  // should report.
  function automatic msis_out_t supervise_tick(input msis_in_t t);
    logic permit;
    logic disabled;
    logic digest;
    logic [31:0] age;
    logic [3:0] verdict;
    msis_out_t r;
    permit = t.status_flags[ST_PERMIT];
    disabled = t.status_flags[ST_DISABLED];
    digest = t.status_flags[ST_DIGEST];
    if (!t.status_flags[ST_VALID]) begin
      // Invalid inputs win in every mode, even over an existing latch.
      trip(FAULT_INVALID);
    end else if (ilk_mode == MODE_LATCHED) begin
      // Only the fully guarded reset request unlatches; clock is ignored here.
      ilk_beat = 1'b0;
      if (t.status_flags[ST_RESET] && !permit && disabled && digest &&
          t.observed_torque_mask == '0 && t.observed_bus_mask == '0) begin
        ilk_mode = MODE_SAFE;
        ilk_fault = FAULT_NONE;
        ilk_flag = 1'b0;
        ilk_reject = REJ_NO_REQUEST;
        ilk_permit_seen = 1'b0;
        ilk_boot = '0;
      end
    end else begin
      ilk_beat = ~ilk_beat;
      if (ilk_time_seen && t.now_time_ms < ilk_last_time) begin
        trip(FAULT_ROLLBACK);
      end else begin
        ilk_time_seen = 1'b1;
        ilk_last_time = t.now_time_ms;
        if (!digest) begin
          trip(FAULT_CONFIG);
        end else if (!disabled || (t.observed_torque_mask & lim_axes) != '0) begin
          trip(FAULT_TORQUE);
        end else if ((t.observed_bus_mask & lim_buses) != '0) begin
          trip(FAULT_BUS_TX);
        end else if (ilk_permit_seen && !permit) begin
          trip(FAULT_DROPOUT);
        end else if (ilk_boot < BOOT_TICKS) begin
          ilk_boot = ilk_boot + 2'd1;
          ilk_mode = MODE_BOOT;
          ilk_reject = REJ_NO_REQUEST;
        end else if (!permit) begin
          ilk_mode = MODE_SAFE;
          ilk_reject = REJ_NO_REQUEST;
        end else begin
          // Permit observed: screen the request, first failing check wins.
          ilk_permit_seen = 1'b1;
          ilk_mode = MODE_PERMIT;
          age = t.now_time_ms - t.request_issued_ms;
          if (!t.request_flags[RQ_PRESENT]) verdict = REJ_NO_REQUEST;
          else if (!t.request_flags[RQ_AUTH]) verdict = REJ_UNAUTH;
          else if (!t.request_flags[RQ_SUPER]) verdict = REJ_UNSUPERVISED;
          else if (t.request_expiry_ms == '0 || t.request_expiry_ms > lim_expiry)
            verdict = REJ_EXPIRY_RANGE;
          else if (age > {16'd0, t.request_expiry_ms}) verdict = REJ_EXPIRED;
          else if (t.request_sequence <= ilk_highest) verdict = REJ_REPLAY;
          else if (t.request_speed_permille > SPEED_LIMIT) verdict = REJ_SPEED;
          else if (!t.request_flags[RQ_STOP]) verdict = REJ_LOCKED;
          else verdict = REJ_NONE;
          ilk_reject = verdict;
          if (verdict == REJ_NONE) begin
            ilk_highest = t.request_sequence;
            ilk_accepted = t.request_sequence;
            grants++;
          end
        end
      end
    end
    r.mode = ilk_mode;
    r.fault_code = ilk_fault;
    r.fault_flag = ilk_flag;
    r.heartbeat = ilk_beat;
    r.reject_code = ilk_reject;
    r.accepted_sequence = ilk_accepted;
    return r;
  endfunction

  // A healthy tick with nothing observed and no request.
  function automatic msis_in_t clean_tick(input logic [31:0] stamp, input logic permit);
    msis_in_t t;
    t = '0;
    t.now_time_ms = stamp;
    t.status_flags = ST_HEALTHY | (permit ? ST_PERMIT_BIT : 5'd0);
    return t;
  endfunction

  // A tick that satisfies every guard of the latched-fault reset.
  function automatic msis_in_t guarded_clear(input logic [31:0] stamp);
    msis_in_t t;
    t = '0;
    t.now_time_ms = stamp;
    t.status_flags = ST_CLEAR_REQ;
    return t;
  endfunction

  // Build the next random tick. Mostly well-formed traffic that follows the
  // current mode so boot, permit and request screening are reached often;
  // the rest is arbitrary noise, injected faults and broken requests.
  function automatic msis_in_t compose_tick();
    msis_in_t t;
    int pick;
    logic [15:0] window;
    t.now_time_ms = $urandom;
    t.status_flags = 5'($urandom);
    t.observed_torque_mask = $urandom;
    t.observed_bus_mask = 16'($urandom);
    t.request_flags = 4'($urandom);
    t.request_expiry_ms = 16'($urandom);
    t.request_issued_ms = $urandom;
    t.request_sequence = $urandom;
    t.request_speed_permille = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 4) return t;

    if (ilk_mode == MODE_LATCHED) begin
      // Try to unlatch; now and then miss one guard.
      t.status_flags = ST_CLEAR_REQ;
      t.observed_torque_mask = '0;
      t.observed_bus_mask = '0;
      if (pick < 30) begin
        case ($urandom_range(5))
          0: t.status_flags[ST_RESET] = 1'b0;
          1: t.status_flags[ST_PERMIT] = 1'b1;
          2: t.status_flags[ST_DISABLED] = 1'b0;
          3: t.observed_torque_mask = 32'd1 << $urandom_range(31);
          4: t.observed_bus_mask = 16'd1 << $urandom_range(15);
          default: t.status_flags[ST_DIGEST] = 1'b0;
        endcase
      end
      return t;
    end

    // Keep time moving forward, with a rare large jump.
    t.now_time_ms = ilk_last_time +
                    ((pick == 99) ? $urandom_range(32'h10_0000) : $urandom_range(60));
    t.status_flags = ST_HEALTHY;
    t.status_flags[ST_RESET] = 1'($urandom);
    t.status_flags[ST_PERMIT] = ilk_permit_seen || ($urandom_range(3) != 0);
    t.observed_torque_mask = $urandom & ~lim_axes;
    t.observed_bus_mask = 16'($urandom) & ~lim_buses;

    window = (lim_expiry == '0) ? 16'($urandom_range(1, 65535))
                                : 16'($urandom_range(1, lim_expiry));
    t.request_flags = RQ_ALL;
    t.request_expiry_ms = window;
    t.request_issued_ms = t.now_time_ms - $urandom_range(window);
    t.request_sequence = ilk_highest +
                         ((pick > 95) ? $urandom_range(1, 32'h100_0000) : $urandom_range(1, 4));
    t.request_speed_permille = 16'($urandom_range(SPEED_LIMIT));

    // Inject one fault on a few ticks.
    case (pick)
      4, 5: if (ilk_last_time != '0) t.now_time_ms = $urandom_range(ilk_last_time - 1);
      6: t.status_flags[ST_DIGEST] = 1'b0;
      7: t.status_flags[ST_DISABLED] = 1'b0;
      8: t.observed_torque_mask |= lim_axes & (32'd1 << $urandom_range(31));
      9: t.observed_bus_mask |= lim_buses & (16'd1 << $urandom_range(15));
      10: t.status_flags[ST_PERMIT] = 1'b0;
      default: ;
    endcase

    // Break the request on a good share of ticks.
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(9))
        0: t.request_flags[RQ_PRESENT] = 1'b0;
        1: t.request_flags[RQ_AUTH] = 1'b0;
        2: t.request_flags[RQ_SUPER] = 1'b0;
        3: t.request_expiry_ms = '0;
        4: t.request_expiry_ms = (lim_expiry != 16'hFFFF) ?
                                 16'($urandom_range(lim_expiry + 1, 65535)) : 16'd0;
        5: t.request_issued_ms = t.now_time_ms - window - 1 - $urandom_range(1000);
        6: t.request_issued_ms = t.now_time_ms + 1 + $urandom_range(1000);
        7: t.request_sequence = $urandom_range(ilk_highest);
        8: t.request_speed_permille = 16'($urandom_range(SPEED_LIMIT + 1, 65535));
        default: t.request_flags[RQ_STOP] = 1'b0;
      endcase
    end
    return t;
  endfunction

  // Offer one tick word, optionally after an idle gap, and hold it until taken.
  // Valid is left high afterwards so back-to-back words need no re-raise.
  task automatic send_tick(input msis_in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(supervise_tick(w));
    ticks_sent++;
  endtask

  // Drop valid and wait until every owed status word has been checked.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Write one register; valid stays high so writes can follow back to back.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_EXPIRY: lim_expiry = value[15:0];
      CFG_AXIS_MASK: lim_axes = value;
      CFG_BUS_MASK: lim_buses = value[15:0];
      default: ;
    endcase
  endtask

  // Program all three limits while idle; junk in the unused upper bits and a
  // write to the empty index must change nothing.
  task automatic set_limits(input logic [15:0] expiry, input logic [31:0] axes,
                            input logic [15:0] buses);
    write_register(CFG_MAX_EXPIRY, {16'($urandom), expiry});
    write_register(CFG_AXIS_MASK, axes);
    write_register(CFG_BUS_MASK, {16'($urandom), buses});
    write_register(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int items, input int sender_idle,
                                  input int receiver_stall);
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (items) send_tick(compose_tick());
    settle();
  endtask

  // Invalid inputs from reset, the guarded clear, boot hold, safe hold and
  // the first permit tick.
  task automatic test_boot_sequence();
    msis_in_t t;
    t = '1;
    t.status_flags[ST_VALID] = 1'b0;
    send_tick(t);
    send_tick('0);
    send_tick(guarded_clear(32'hFFFF_FFFF));
    send_tick(clean_tick(32'd100, 1'b0));
    send_tick(clean_tick(32'd100, 1'b1));
    send_tick(clean_tick(32'd150, 1'b1));
    send_tick(clean_tick(32'd200, 1'b0));
    send_tick(clean_tick(32'd210, 1'b1));
  endtask

  // Walk every request check after the presence check in order, then accept one right at the limits.
  task automatic test_request_screening();
    msis_in_t t;
    for (int k = 0; k < 10; k++) begin
      t = clean_tick(ilk_last_time + 32'd10, 1'b1);
      t.request_flags = RQ_ALL;
      t.request_expiry_ms = 16'd500;
      t.request_issued_ms = t.now_time_ms - 32'd100;
      t.request_sequence = 32'd10;
      t.request_speed_permille = 16'd100;
      case (k)
        0: t.request_flags[RQ_AUTH] = 1'b0;
        1: t.request_flags[RQ_SUPER] = 1'b0;
        2: t.request_expiry_ms = '0;
        3: t.request_expiry_ms = lim_expiry + 16'd1;
        4: t.request_issued_ms = t.now_time_ms - 32'd501;
        5: t.request_issued_ms = t.now_time_ms + 32'd1;   // wraps to a huge age
        6: t.request_sequence = '0;
        7: t.request_speed_permille = SPEED_LIMIT + 16'd1;
        8: t.request_flags[RQ_STOP] = 1'b0;
        default: begin
          t.request_expiry_ms = lim_expiry;
          t.request_issued_ms = t.now_time_ms - {16'd0, lim_expiry};
          t.request_speed_permille = SPEED_LIMIT;
        end
      endcase
      send_tick(t);
    end
  endtask

  // Permit dropout first (needs permit seen), then config, torque, bus and
  // rollback faults, most mixing in a lower-priority fault, each then cleared.
  task automatic test_fault_priority();
    msis_in_t t;
    for (int k = 0; k < 5; k++) begin
      t = clean_tick(ilk_last_time + 32'd10, 1'b1);
      case (k)
        0: t.status_flags[ST_PERMIT] = 1'b0;
        1: begin
          t.status_flags[ST_DIGEST] = 1'b0;
          t.observed_torque_mask = 32'd1;
        end
        2: begin
          t.observed_torque_mask = 32'h8000_0000;
          t.observed_bus_mask = 16'h0001;
        end
        3: t.observed_bus_mask = 16'h8000;
        default: begin
          t.now_time_ms = ilk_last_time - 32'd1;
          t.status_flags[ST_DIGEST] = 1'b0;
        end
      endcase
      send_tick(t);
      send_tick(guarded_clear(ilk_last_time));
    end
  endtask

  // Hold the receiver off long enough to fill the block and stall the input,
  // then let the sender pause until everything owed is back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 200;
    repeat (40) send_tick(compose_tick());
    settle();
    stall_pct = 30;
    repeat (20) send_tick(compose_tick());
    settle();
  endtask

  // Long random runs under several limit settings and idle mixes.
  task automatic test_random_traffic();
    run_random_phase(250, 0, 0);
    set_limits(16'd1, '0, '0);
    run_random_phase(250, 62, 0);
    set_limits(16'hFFFF, $urandom, 16'($urandom));
    run_random_phase(250, 0, 62);
    set_limits(16'd0, $urandom & $urandom, 16'($urandom & $urandom));
    run_random_phase(200, 11, 11);
    set_limits(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    run_random_phase(300, 0, 0);
    set_limits(16'($urandom_range(1, 65535)), $urandom, 16'($urandom));
    run_random_phase(300, 11, 11);
  endtask

  // Receiver: random stalls per phase, overridden by a counted hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_req <= hold_req - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      field_errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: status word %0d, %s expected %0h got %0h",
                 $realtime, words_checked, name, want, seen);
      end
    end
  endtask

  // Check each status word taken from the block against the oldest one owed.
  always @(posedge clk) begin
    msis_out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        stray_words++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: status word %h arrived with none owed", $realtime, out_data);
        end
      end else begin
        due = pending_status.pop_front();
        check_field("mode", 32'(due.mode), 32'(out_data.mode));
        check_field("fault_code", 32'(due.fault_code), 32'(out_data.fault_code));
        check_field("fault_flag", 32'(due.fault_flag), 32'(out_data.fault_flag));
        check_field("heartbeat", 32'(due.heartbeat), 32'(out_data.heartbeat));
        check_field("reject_code", 32'(due.reject_code), 32'(out_data.reject_code));
        check_field("accepted_sequence", due.accepted_sequence, out_data.accepted_sequence);
        words_checked++;
      end
    end
  end

  initial begin
    // Hold reset, then run the tests in turn.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_boot_sequence();
    test_request_screening();
    test_fault_priority();
    test_backpressure();
    test_random_traffic();
    settle();
    // Give a stray extra word time to show up.
    repeat (10) @(posedge clk);
    $display("Sent %0d control ticks and checked %0d status words over six limit settings",
             ticks_sent, words_checked);
    $display("Faults latched %0d, stop requests granted %0d, field mismatches %0d, strays %0d",
             trips, grants, field_errors, stray_words);
    if (field_errors == 0 && stray_words == 0 && pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Run timed out with %0d status words owed", pending_status.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
design/msis_pkg.sv
design/msis_core.sv
design/motion_safety_interlock_supervisor.sv
design/msis_checker.sv
test/tb.sv
